@@ hw/rtl/hcd_pkg.sv @@
// ----------------------------------------------------------------------------
// hcd_pkg
// Shared types and constants of the chunked body decoder.
// ----------------------------------------------------------------------------
package hcd_pkg;

   localparam int SIZE_BITS_DEFAULT   = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int          SIG_W          = 5;
   localparam logic [4:0]  MAX_SIG_DIGITS = 5'd16;
   localparam logic [1:0]  TRAILER_LEN    = 2'd2;

   localparam logic [2:0] ST_ZERO       = 3'd0;
   localparam logic [2:0] ST_CLEAN      = 3'd1;
   localparam logic [2:0] ST_MALFORMED  = 3'd2;
   localparam logic [2:0] ST_TRUNCATED  = 3'd3;
   localparam logic [2:0] ST_INCOMPLETE = 3'd4;

   localparam logic [7:0] CH_CR = 8'h0d;
   localparam logic [7:0] CH_LF = 8'h0a;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic [3:0] digit;
      logic       is_hex;
      logic       is_space;
      logic       is_cr;
      logic       is_lf;
      logic       is_x;
   } hcd_item_type;

endpackage

@@ hw/rtl/hcd_front.sv @@
// ----------------------------------------------------------------------------
// hcd_front
// Input stage: accepts raw body bytes and tags each with its character class.
// ----------------------------------------------------------------------------
module hcd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [7:0]            req_in_byte,
   input  logic                  req_in_last,
   output logic                  item_valid,
   input  logic                  item_ready,
   output hcd_pkg::hcd_item_type item
);

   logic                  valid_ff, valid_in;
   hcd_pkg::hcd_item_type item_ff, item_in;
   logic                  accept;

   assign req_full   = valid_ff && !item_ready;
   assign accept     = req_push && !req_full;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      item_in          = '0;
      item_in.data     = req_in_byte;
      item_in.last     = req_in_last;
      item_in.is_cr    = (req_in_byte == hcd_pkg::CH_CR);
      item_in.is_lf    = (req_in_byte == hcd_pkg::CH_LF);
      item_in.is_x     = (req_in_byte == 8'h78) || (req_in_byte == 8'h58);
      item_in.is_space = (req_in_byte == 8'h20) ||
                         (req_in_byte >= 8'h09 && req_in_byte <= 8'h0d);
      if (req_in_byte >= 8'h30 && req_in_byte <= 8'h39) begin
         item_in.is_hex = 1'b1;
         item_in.digit  = 4'(req_in_byte - 8'h30);
      end else if (req_in_byte >= 8'h61 && req_in_byte <= 8'h66) begin
         item_in.is_hex = 1'b1;
         item_in.digit  = 4'(req_in_byte - 8'h57);
      end else if (req_in_byte >= 8'h41 && req_in_byte <= 8'h46) begin
         item_in.is_hex = 1'b1;
         item_in.digit  = 4'(req_in_byte - 8'h37);
      end
   end

   assign valid_in = accept || (valid_ff && !item_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ hw/rtl/hcd_queue.sv @@
// ----------------------------------------------------------------------------
// hcd_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module hcd_queue #(
   parameter int DEPTH = hcd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  hcd_pkg::hcd_item_type push_item,
   input  logic                  pop,
   output logic                  empty,
   output hcd_pkg::hcd_item_type head_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   hcd_pkg::hcd_item_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ hw/rtl/hcd_back.sv @@
// ----------------------------------------------------------------------------
// hcd_back
// Decoder proper: walks size lines, payload and trailer, and holds the result.
// ----------------------------------------------------------------------------
module hcd_back #(
   parameter int SIZE_BITS = hcd_pkg::SIZE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   output logic                  item_take,
   input  hcd_pkg::hcd_item_type item,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_out_has_byte,
   output logic                  rsp_out_chunk_first,
   output logic                  rsp_out_done,
   output logic [2:0]            rsp_out_status
);

   typedef enum logic [2:0] {
      PH_LEAD, PH_DIGITS, PH_TRAIL, PH_BADLINE,
      PH_PAYLOAD, PH_SKIP, PH_STOPZERO, PH_STOPBAD
   } phase_type;

   phase_type                   phase_ff, phase_in, phase_mid;
   logic [SIZE_BITS-1:0]        size_ff, size_in;
   logic [hcd_pkg::SIG_W-1:0]   sig_ff, sig_in;
   logic                        digit_seen_ff, digit_seen_in;
   logic                        lone_zero_ff, lone_zero_in;
   logic                        pending_cr_ff, pending_cr_in;
   logic                        line_chars_ff, line_chars_in;
   logic [1:0]                  skip_ff, skip_in;
   logic                        first_ff, first_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [7:0]                  byte_ff, byte_in;
   logic                        has_ff, has_in;
   logic                        chunk_first_ff, chunk_first_in;
   logic                        done_ff, done_in;
   logic [2:0]                  status_ff, status_in;
   logic                        emit;
   logic [SIZE_BITS-1:0]        size_dec;

   assign item_take           = item_valid && (!rsp_valid_ff || rsp_pop);
   assign rsp_empty           = !rsp_valid_ff;
   assign rsp_out_byte        = byte_ff;
   assign rsp_out_has_byte    = has_ff;
   assign rsp_out_chunk_first = chunk_first_ff;
   assign rsp_out_done        = done_ff;
   assign rsp_out_status      = status_ff;
   assign size_dec            = size_ff - 1'b1;

   always_comb begin
      phase_in      = phase_ff;
      phase_mid     = phase_ff;
      size_in       = size_ff;
      sig_in        = sig_ff;
      digit_seen_in = digit_seen_ff;
      lone_zero_in  = lone_zero_ff;
      pending_cr_in = pending_cr_ff;
      line_chars_in = line_chars_ff;
      skip_in       = skip_ff;
      first_in      = first_ff;
      has_in        = 1'b0;
      byte_in       = '0;
      chunk_first_in = 1'b0;
      done_in       = 1'b0;
      status_in     = hcd_pkg::ST_ZERO;

      unique case (phase_ff)
         PH_LEAD, PH_DIGITS, PH_TRAIL, PH_BADLINE: begin
            line_chars_in = 1'b1;
            if (pending_cr_ff && item.is_lf) begin
               pending_cr_in = 1'b0;
               if (phase_ff == PH_BADLINE || !digit_seen_ff) begin
                  phase_in = PH_STOPBAD;
               end else if (size_ff == '0) begin
                  phase_in = PH_STOPZERO;
               end else begin
                  phase_in = PH_PAYLOAD;
                  first_in = 1'b1;
               end
               if (phase_in != PH_PAYLOAD) begin
                  size_in = '0;
               end
               sig_in        = '0;
               digit_seen_in = 1'b0;
               lone_zero_in  = 1'b0;
               line_chars_in = 1'b0;
            end else begin
               // a lone CR acts as an ordinary line character first
               if (pending_cr_ff) begin
                  pending_cr_in = 1'b0;
                  lone_zero_in  = 1'b0;
                  if (phase_ff == PH_DIGITS) begin
                     phase_mid = PH_TRAIL;
                  end
               end
               phase_in = phase_mid;
               if (item.is_cr) begin
                  pending_cr_in = 1'b1;
               end else if (phase_mid == PH_LEAD) begin
                  if (!item.is_space) begin
                     if (!item.is_hex) begin
                        phase_in = PH_BADLINE;
                     end else begin
                        phase_in      = PH_DIGITS;
                        digit_seen_in = 1'b1;
                        lone_zero_in  = (item.digit == 4'd0);
                        if (!(sig_in == '0 && item.digit == 4'd0)) begin
                           sig_in = sig_in + 1'b1;
                           if (sig_in > hcd_pkg::MAX_SIG_DIGITS) begin
                              phase_in = PH_BADLINE;
                           end else begin
                              size_in = {size_in[SIZE_BITS-5:0], item.digit};
                           end
                        end
                     end
                  end
               end else if (phase_mid == PH_DIGITS) begin
                  if (lone_zero_in && item.is_x) begin
                     lone_zero_in = 1'b0;
                  end else begin
                     lone_zero_in = 1'b0;
                     if (!item.is_hex) begin
                        phase_in = PH_TRAIL;
                     end else if (!(sig_in == '0 && item.digit == 4'd0)) begin
                        sig_in = sig_in + 1'b1;
                        if (sig_in > hcd_pkg::MAX_SIG_DIGITS) begin
                           phase_in = PH_BADLINE;
                        end else begin
                           size_in = {size_in[SIZE_BITS-5:0], item.digit};
                        end
                     end
                  end
               end
            end
         end
         PH_PAYLOAD: begin
            has_in         = 1'b1;
            byte_in        = item.data;
            chunk_first_in = first_ff;
            first_in       = 1'b0;
            size_in        = size_dec;
            if (size_dec == '0) begin
               phase_in = PH_SKIP;
               skip_in  = hcd_pkg::TRAILER_LEN;
            end
         end
         PH_SKIP: begin
            skip_in = skip_ff - 1'b1;
            if (skip_in == 2'd0) begin
               phase_in      = PH_LEAD;
               size_in       = '0;
               sig_in        = '0;
               digit_seen_in = 1'b0;
               lone_zero_in  = 1'b0;
               pending_cr_in = 1'b0;
               line_chars_in = 1'b0;
            end
         end
         PH_STOPZERO, PH_STOPBAD: begin
         end
      endcase

      if (item.last) begin
         done_in = 1'b1;
         unique case (phase_in)
            PH_STOPZERO: status_in = hcd_pkg::ST_ZERO;
            PH_STOPBAD:  status_in = hcd_pkg::ST_MALFORMED;
            PH_PAYLOAD:  status_in = hcd_pkg::ST_TRUNCATED;
            PH_SKIP:     status_in = hcd_pkg::ST_CLEAN;
            default:     status_in = line_chars_in ? hcd_pkg::ST_INCOMPLETE
                                                   : hcd_pkg::ST_CLEAN;
         endcase
         phase_in      = PH_LEAD;
         size_in       = '0;
         sig_in        = '0;
         digit_seen_in = 1'b0;
         lone_zero_in  = 1'b0;
         pending_cr_in = 1'b0;
         line_chars_in = 1'b0;
         skip_in       = '0;
         first_in      = 1'b0;
      end
   end

   assign emit         = has_in || done_in;
   assign rsp_valid_in = item_take ? emit : (rsp_valid_ff && !rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LEAD;
         size_ff       <= '0;
         sig_ff        <= '0;
         digit_seen_ff <= 1'b0;
         lone_zero_ff  <= 1'b0;
         pending_cr_ff <= 1'b0;
         line_chars_ff <= 1'b0;
         skip_ff       <= '0;
         first_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_take) begin
            phase_ff      <= phase_in;
            size_ff       <= size_in;
            sig_ff        <= sig_in;
            digit_seen_ff <= digit_seen_in;
            lone_zero_ff  <= lone_zero_in;
            pending_cr_ff <= pending_cr_in;
            line_chars_ff <= line_chars_in;
            skip_ff       <= skip_in;
            first_ff      <= first_in;
         end
      end
      if (item_take && emit) begin
         byte_ff        <= byte_in;
         has_ff         <= has_in;
         chunk_first_ff <= chunk_first_in;
         done_ff        <= done_in;
         status_ff      <= status_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> size_ff != '0)
      else $error("payload phase with nothing left");

   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> skip_ff != 2'd0)
      else $error("trailer skip with count exhausted");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && chunk_first_ff |-> has_ff)
      else $error("chunk start flagged without a payload byte");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !done_ff |-> has_ff && status_ff == hcd_pkg::ST_ZERO)
      else $error("result without byte or end of body");

endmodule

@@ hw/rtl/http_chunked_decoder_core.sv @@
// ----------------------------------------------------------------------------
// http_chunked_decoder_core
// Streaming decoder for HTTP chunked bodies, one byte in per cycle while results are popped.
// ----------------------------------------------------------------------------
// Sustains one body byte per clock: the decoder state machine in the back
// stage updates its size, digit and trailer state as it takes each byte, so
// a new byte can enter every cycle for as long as results are popped. A byte
// passes the classify register, the queue and the result register, in that
// order, before its result shows. Only payload bytes and the body's last byte
// give a result; size lines and the CR LF after each payload are consumed
// silently. The queue between front and back, together with the classify
// register, holds up to QUEUE_DEPTH + 1 items, so the input keeps flowing
// while the result side stalls until both are filled.
module http_chunked_decoder_core #(
   parameter int SIZE_BITS   = hcd_pkg::SIZE_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = hcd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_has_byte,
   output logic       rsp_out_chunk_first,
   output logic       rsp_out_done,
   output logic [2:0] rsp_out_status
);

   logic                  front_valid, queue_full, queue_empty, back_take;
   hcd_pkg::hcd_item_type front_item, head_item;

   hcd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (push),
      .req_full    (full),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .item_valid  (front_valid),
      .item_ready  (!queue_full),
      .item        (front_item)
   );

   hcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .full      (queue_full),
      .push_item (front_item),
      .pop       (back_take),
      .empty     (queue_empty),
      .head_item (head_item)
   );

   hcd_back #(
      .SIZE_BITS (SIZE_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .item_valid          (!queue_empty),
      .item_take           (back_take),
      .item                (head_item),
      .rsp_empty           (empty),
      .rsp_pop             (pop),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_out_has_byte    (rsp_out_has_byte),
      .rsp_out_chunk_first (rsp_out_chunk_first),
      .rsp_out_done        (rsp_out_done),
      .rsp_out_status      (rsp_out_status)
   );

endmodule
